FILE: design/bsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsv_pkg: shared types and constants of the bundle stream validator
// Result record layout, push request, status and kind codes, FNV constants
// and the header magic.
// ----------------------------------------------------------------------------
package bsv_pkg;

  localparam int OFFSET_BITS_DEFAULT = 24;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Images shorter than this are reported as too short
  localparam int MIN_LEN = 32;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
  localparam logic [2:0] STATUS_CHECKSUM  = 3'd3;
  localparam logic [2:0] STATUS_TRUNC     = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [23:0] name_offset;
    logic [23:0] name_length;
    logic [23:0] data_offset;
    logic [31:0] data_length;
    logic [2:0]  status;
    logic        last_in_run;
  } result_t;

  // Results produced by one byte; count is zero when nothing is pushed
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Expected header magic, one byte per position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h53;
      3'd2:    b = 8'h50;
      3'd3:    b = 8'h4B;
      3'd4:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/bsv_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsv_result_queue: two-entry result queue
// Holds up to two results; the head drives the output port. Reports how many
// slots will be free after this cycle's pop so the parser can push at once.
// ----------------------------------------------------------------------------
module bsv_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  bsv_pkg::push_t  push,
  output logic [1:0]      room,
  output logic            result_valid,
  input  logic            result_ready,
  output bsv_pkg::result_t head
);

  logic [1:0]       cnt;
  logic [1:0]       cnt_next;
  logic [1:0]       kept;
  logic             pop;
  bsv_pkg::result_t q0;
  logic             unused_q1_sel;
  bsv_pkg::result_t q1;
  bsv_pkg::result_t q0_next;
  bsv_pkg::result_t q1_next;
  bsv_pkg::result_t base0;

  assign unused_q1_sel = 1'b0;

  // Work out occupancy after this cycle's pop
  assign pop          = (cnt != 2'd0) && result_ready;
  assign kept         = cnt - {1'b0, pop};
  assign room         = 2'd2 - kept;
  assign result_valid = (cnt != 2'd0);
  assign head         = q0;

  // Shift on pop, then append the pushed results behind what is kept
  always_comb begin
    base0    = pop ? q1 : q0;
    q0_next  = q0;
    q1_next  = q1;
    cnt_next = kept + push.count;
    case (kept)
      2'd0: begin
        q0_next = push.first;
        q1_next = push.second;
      end
      2'd1: begin
        q0_next = base0;
        q1_next = push.first;
      end
      default: begin
        q0_next = q0;
        q1_next = q1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    q0 <= q0_next;
    q1 <= q1_next | {$bits(bsv_pkg::result_t){unused_q1_sel}};
  end

endmodule

FILE: design/bsv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsv_parser: input register and container parse step
// Registers one request, then in a single step updates the header checks,
// the FNV-1a hash and the entry walk, and pushes a record and/or verdict.
// ----------------------------------------------------------------------------
module bsv_parser #(
  parameter int OFFSET_BITS = bsv_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [7:0]     data_byte,
  input  logic           last,
  input  logic [1:0]     room,
  output bsv_pkg::push_t push
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_LEN,
    PH_PAD1,
    PH_DATA,
    PH_PAD2
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OFF_ONE      = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OFF_FOUR     = OFFSET_BITS'(4);
  localparam logic [OFFSET_BITS-1:0] OFF_MAGIC    = OFFSET_BITS'(8);
  localparam logic [OFFSET_BITS-1:0] OFF_CHK      = OFFSET_BITS'(12);
  localparam logic [OFFSET_BITS-1:0] OFF_HDR_END  = OFFSET_BITS'(15);
  localparam logic [OFFSET_BITS-1:0] OFF_BLOCK    = OFFSET_BITS'(16);
  localparam logic [OFFSET_BITS-1:0] OFF_MASK_LOW = OFFSET_BITS'(15);
  localparam logic [OFFSET_BITS-1:0] OFF_SHORT    = OFFSET_BITS'(bsv_pkg::MIN_LEN - 1);

  // Input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // Parse state
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   magic_ok;
  logic [31:0]            stored_checksum;
  logic [31:0]            running_hash;
  phase_t                 phase;
  logic [OFFSET_BITS-1:0] entry_name_start;
  logic [31:0]            length_shift;
  logic [1:0]             length_byte_count;
  logic [31:0]            data_remaining;
  logic                   wrapped;

  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic                   magic_ok_next;
  logic [31:0]            stored_checksum_next;
  logic [31:0]            running_hash_next;
  phase_t                 phase_next;
  logic [OFFSET_BITS-1:0] entry_name_start_next;
  logic [31:0]            length_shift_next;
  logic [1:0]             length_byte_count_next;
  logic [31:0]            data_remaining_next;
  logic                   wrapped_next;

  logic                   nxt_aligned;
  logic [31:0]            hash_mix;
  logic [31:0]            rem_dec;
  logic                   rec_emit;
  logic                   trunc;
  logic [2:0]             verdict_status;
  logic [OFFSET_BITS-1:0] rec_nlen;
  logic [OFFSET_BITS-1:0] rec_doff;
  logic [1:0]             n_results;
  logic                   accept;
  bsv_pkg::result_t       rec_res;
  bsv_pkg::result_t       verd_res;

  // FNV-1a step: xor the byte in, multiply by the prime
  assign hash_mix = (running_hash ^ {24'd0, in_byte}) * bsv_pkg::FNV_PRIME;

  assign byte_offset_next = byte_offset + OFF_ONE;
  assign nxt_aligned      = (byte_offset_next[3:0] == 4'd0);
  assign rem_dec          = (data_remaining != 32'd0) ? data_remaining - 32'd1 : data_remaining;
  assign rec_nlen         = byte_offset - OFF_FOUR - entry_name_start;
  assign rec_doff         = (byte_offset + OFF_BLOCK) & ~OFF_MASK_LOW;
  assign wrapped_next     = wrapped | (byte_offset_next == '0);

  // Advance the header checks and the entry walk by one byte
  always_comb begin
    magic_ok_next          = magic_ok;
    stored_checksum_next   = stored_checksum;
    running_hash_next      = running_hash;
    phase_next             = phase;
    entry_name_start_next  = entry_name_start;
    length_shift_next      = length_shift;
    length_byte_count_next = length_byte_count;
    data_remaining_next    = data_remaining;
    rec_emit               = 1'b0;

    if (phase != PH_HEADER) begin
      running_hash_next = hash_mix;
    end

    case (phase)
      PH_HEADER: begin
        if (byte_offset < OFF_MAGIC && in_byte != bsv_pkg::magic_byte(byte_offset[2:0])) begin
          magic_ok_next = 1'b0;
        end
        if (byte_offset >= OFF_CHK) begin
          stored_checksum_next = {stored_checksum[23:0], in_byte};
        end
        if (byte_offset >= OFF_HDR_END) begin
          phase_next            = PH_NAME;
          entry_name_start_next = byte_offset_next;
        end
      end
      PH_NAME: begin
        if (in_byte == 8'd0) begin
          phase_next             = PH_LEN;
          length_shift_next      = 32'd0;
          length_byte_count_next = 2'd0;
        end
      end
      PH_LEN: begin
        length_shift_next = {length_shift[23:0], in_byte};
        if (length_byte_count == 2'd3) begin
          rec_emit               = 1'b1;
          data_remaining_next    = {length_shift[23:0], in_byte};
          length_byte_count_next = 2'd0;
          if (nxt_aligned) begin
            if (data_remaining_next != 32'd0) begin
              phase_next = PH_DATA;
            end else begin
              phase_next            = PH_NAME;
              entry_name_start_next = byte_offset_next;
            end
          end else begin
            phase_next = PH_PAD1;
          end
        end else begin
          length_byte_count_next = length_byte_count + 2'd1;
        end
      end
      PH_PAD1: begin
        if (nxt_aligned) begin
          if (data_remaining != 32'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next            = PH_NAME;
            entry_name_start_next = byte_offset_next;
          end
        end
      end
      PH_DATA: begin
        data_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          if (nxt_aligned) begin
            phase_next            = PH_NAME;
            entry_name_start_next = byte_offset_next;
          end else begin
            phase_next = PH_PAD2;
          end
        end
      end
      default: begin
        if (nxt_aligned) begin
          phase_next            = PH_NAME;
          entry_name_start_next = byte_offset_next;
        end
      end
    endcase
  end

  // Judge the image on its final byte
  always_comb begin
    trunc = (phase_next == PH_LEN) ||
            (phase_next == PH_NAME && entry_name_start_next != byte_offset_next) ||
            ((phase_next == PH_PAD1 || phase_next == PH_DATA) && data_remaining_next != 32'd0);
    if (!wrapped && byte_offset < OFF_SHORT) begin
      verdict_status = bsv_pkg::STATUS_SHORT;
    end else if (!magic_ok_next) begin
      verdict_status = bsv_pkg::STATUS_BAD_MAGIC;
    end else if (running_hash_next != stored_checksum_next) begin
      verdict_status = bsv_pkg::STATUS_CHECKSUM;
    end else if (trunc) begin
      verdict_status = bsv_pkg::STATUS_TRUNC;
    end else begin
      verdict_status = bsv_pkg::STATUS_OK;
    end
  end

  // Build the results of this byte
  always_comb begin
    rec_res.kind        = bsv_pkg::KIND_RECORD;
    rec_res.name_offset = 24'(32'(entry_name_start));
    rec_res.name_length = 24'(32'(rec_nlen));
    rec_res.data_offset = 24'(32'(rec_doff));
    rec_res.data_length = length_shift_next;
    rec_res.status      = bsv_pkg::STATUS_OK;
    rec_res.last_in_run = ~in_last;

    verd_res.kind        = bsv_pkg::KIND_VERDICT;
    verd_res.name_offset = 24'd0;
    verd_res.name_length = 24'd0;
    verd_res.data_offset = 24'd0;
    verd_res.data_length = 32'd0;
    verd_res.status      = verdict_status;
    verd_res.last_in_run = 1'b1;
  end

  assign n_results    = {1'b0, rec_emit} + {1'b0, in_last};
  assign accept       = in_full && (n_results <= room);
  assign item_ready   = ~in_full | accept;
  assign push.count   = accept ? n_results : 2'd0;
  assign push.first   = rec_emit ? rec_res : verd_res;
  assign push.second  = verd_res;

  // Hold the input register and the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full           <= 1'b0;
      byte_offset       <= '0;
      magic_ok          <= 1'b1;
      stored_checksum   <= 32'd0;
      running_hash      <= bsv_pkg::FNV_BASIS;
      phase             <= PH_HEADER;
      entry_name_start  <= '0;
      length_shift      <= 32'd0;
      length_byte_count <= 2'd0;
      data_remaining    <= 32'd0;
      wrapped           <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        in_full <= 1'b1;
      end else if (accept) begin
        in_full <= 1'b0;
      end
      if (accept) begin
        if (in_last) begin
          // Verdict given: drop back to the start of a new image
          byte_offset       <= '0;
          magic_ok          <= 1'b1;
          stored_checksum   <= 32'd0;
          running_hash      <= bsv_pkg::FNV_BASIS;
          phase             <= PH_HEADER;
          entry_name_start  <= '0;
          length_shift      <= 32'd0;
          length_byte_count <= 2'd0;
          data_remaining    <= 32'd0;
          wrapped           <= 1'b0;
        end else begin
          byte_offset       <= byte_offset_next;
          magic_ok          <= magic_ok_next;
          stored_checksum   <= stored_checksum_next;
          running_hash      <= running_hash_next;
          phase             <= phase_next;
          entry_name_start  <= entry_name_start_next;
          length_shift      <= length_shift_next;
          length_byte_count <= length_byte_count_next;
          data_remaining    <= data_remaining_next;
          wrapped           <= wrapped_next;
        end
      end
    end
    if (item_valid && item_ready) begin
      in_byte <= data_byte;
      in_last <= last;
    end
  end

endmodule

FILE: design/bundle_stream_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bundle_stream_validator_unit: streaming container checker and entry walker
// Input register, single-step parser, two-entry result queue.
// ----------------------------------------------------------------------------
// Takes one image byte per cycle while the result queue has room, with last
// marking the final byte. The 16-byte header is checked (magic, big-endian
// checksum at bytes 12..15) and FNV-1a 32 runs over every byte from offset 16
// on. An entry record is produced when an entry's 4-byte length field
// completes, and a verdict on the final byte, after which the block starts a
// new image. Each byte waits in the input register and is parsed from there
// at one byte per cycle while the queue has room, set by the hash feedback
// through one constant multiply; a record and a verdict from one byte share
// the one result port, via the two-entry queue between parser and output.
module bundle_stream_validator_unit #(
  parameter int OFFSET_BITS = bsv_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        kind,
  output logic [23:0] name_offset,
  output logic [23:0] name_length,
  output logic [23:0] data_offset,
  output logic [31:0] data_length,
  output logic [2:0]  status,
  output logic        last_in_run
);

  bsv_pkg::push_t   push;
  logic [1:0]       room;
  bsv_pkg::result_t head;

  // Parse one request per cycle while the result queue has room
  bsv_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .data_byte (data_byte),
    .last      (last),
    .room      (room),
    .push      (push)
  );

  // Queue results towards the output
  bsv_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .head        (head)
  );

  assign kind        = head.kind;
  assign name_offset = head.name_offset;
  assign name_length = head.name_length;
  assign data_offset = head.data_offset;
  assign data_length = head.data_length;
  assign status      = head.status;
  assign last_in_run = head.last_in_run;

endmodule

FILE: bench/tb_bundle_stream_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bundle_stream_validator_unit: self-checking bench for the image validator
// Streams short directed images, then random well-formed, corrupted, cut and
// stub images, predicting every entry record and verdict in the bench and
// checking each result by field, mostly under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_bundle_stream_validator_unit;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;

  // Header magic, first byte in the top octet
  localparam logic [63:0] HDR_MAGIC = 64'h4553_504B_3100_0000;

  // Directed row: {typed verdict flag, verdict status, last, byte}
  localparam logic [3:0] NOTE_NONE  = {1'b0, bsv_pkg::STATUS_OK};
  localparam logic [3:0] NOTE_SHORT = {1'b1, bsv_pkg::STATUS_SHORT};

  localparam logic [0:23][12:0] DIRECTED_ROWS = {
    // one-byte image
    {NOTE_SHORT, 1'b1, 8'h45},
    // two-byte image, field extremes
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_SHORT, 1'b1, 8'hFF},
    // header with good magic, then an empty name and an all-ones length that
    // ends the image: record and verdict from the same byte
    {NOTE_NONE,  1'b0, 8'h45},
    {NOTE_NONE,  1'b0, 8'h53},
    {NOTE_NONE,  1'b0, 8'h50},
    {NOTE_NONE,  1'b0, 8'h4B},
    {NOTE_NONE,  1'b0, 8'h31},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'hA5},
    {NOTE_NONE,  1'b0, 8'h5A},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_NONE,  1'b0, 8'h00},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_NONE,  1'b0, 8'hFF},
    {NOTE_SHORT, 1'b1, 8'hFF}
  };

  typedef enum logic [2:0] {
    P_HEADER, P_NAME, P_LENGTH, P_PAD_HEAD, P_DATA, P_PAD_TAIL
  } walk_phase_t;

  typedef enum logic [2:0] {
    IMG_CLEAN, IMG_BAD_MAGIC, IMG_BAD_SUM, IMG_CUT, IMG_STUB
  } image_flavour_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        kind;
  logic [23:0] name_offset;
  logic [23:0] name_length;
  logic [23:0] data_offset;
  logic [31:0] data_length;
  logic [2:0]  status;
  logic        last_in_run;

  // Parser state mirrored by the bench
  logic [23:0] walk_pos;
  logic        walk_magic_good;
  logic [31:0] walk_stored_sum;
  logic [31:0] walk_hash;
  walk_phase_t walk_phase;
  logic [23:0] walk_name_start;
  logic [31:0] walk_len_acc;
  logic [1:0]  walk_len_count;
  logic [31:0] walk_data_left;
  logic        walk_wrapped;

  bsv_pkg::result_t expected_results[$];
  logic [7:0]       image_bytes[$];
  int               send_idle = 15;
  int               recv_idle = 70;
  int               mismatches = 0;
  int               cycle_count = 0;

  bundle_stream_validator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .name_offset  (name_offset),
    .name_length  (name_length),
    .data_offset  (data_offset),
    .data_length  (data_length),
    .status       (status),
    .last_in_run  (last_in_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("** bundle_stream_validator_unit: FAILED **");
      $finish;
    end
  end

  task automatic clear_walk();
    walk_pos        = '0;
    walk_magic_good = 1'b1;
    walk_stored_sum = '0;
    walk_hash       = bsv_pkg::FNV_BASIS;
    walk_phase      = P_HEADER;
    walk_name_start = '0;
    walk_len_acc    = '0;
    walk_len_count  = '0;
    walk_data_left  = '0;
    walk_wrapped    = 1'b0;
  endtask

  function automatic void open_name(input logic [23:0] at);
    walk_phase      = P_NAME;
    walk_name_start = at;
  endfunction

  // Advance the parser by one byte and queue the records and verdict it yields
  task automatic walk_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [2:0] typed_status);
    logic [23:0]      p;
    logic [23:0]      nx;
    logic             aligned;
    logic             was_wrapped;
    logic             cut_short;
    bsv_pkg::result_t rec[2];
    int               n;
    p           = walk_pos;
    nx          = p + 24'd1;
    aligned     = (nx[3:0] == 4'h0);
    was_wrapped = walk_wrapped;
    n           = 0;
    if (walk_phase != P_HEADER) begin
      walk_hash = (walk_hash ^ {24'd0, b}) * bsv_pkg::FNV_PRIME;
    end
    case (walk_phase)
      P_HEADER: begin
        if (p < 24'd8 && b != HDR_MAGIC[63 - 8 * p[2:0] -: 8]) walk_magic_good = 1'b0;
        if (p >= 24'd12) walk_stored_sum = {walk_stored_sum[23:0], b};
        if (p >= 24'd15) open_name(nx);
      end
      P_NAME: begin
        if (b == 8'h00) begin
          walk_phase     = P_LENGTH;
          walk_len_acc   = '0;
          walk_len_count = '0;
        end
      end
      P_LENGTH: begin
        walk_len_acc = {walk_len_acc[23:0], b};
        if (walk_len_count == 2'd3) begin
          rec[n].kind        = bsv_pkg::KIND_RECORD;
          rec[n].name_offset = walk_name_start;
          rec[n].name_length = p - 24'd4 - walk_name_start;
          rec[n].data_offset = (p + 24'd16) & 24'hFFFFF0;
          rec[n].data_length = walk_len_acc;
          rec[n].status      = bsv_pkg::STATUS_OK;
          rec[n].last_in_run = 1'b0;
          n++;
          walk_data_left = walk_len_acc;
          walk_len_count = '0;
          if (!aligned) walk_phase = P_PAD_HEAD;
          else if (walk_data_left != 0) walk_phase = P_DATA;
          else open_name(nx);
        end else begin
          walk_len_count = walk_len_count + 2'd1;
        end
      end
      P_PAD_HEAD: begin
        if (aligned) begin
          if (walk_data_left != 0) walk_phase = P_DATA;
          else open_name(nx);
        end
      end
      P_DATA: begin
        if (walk_data_left != 0) walk_data_left = walk_data_left - 32'd1;
        if (walk_data_left == 0) begin
          if (aligned) open_name(nx);
          else walk_phase = P_PAD_TAIL;
        end
      end
      default: begin
        if (aligned) open_name(nx);
      end
    endcase
    walk_pos = nx;
    if (nx == 24'd0) walk_wrapped = 1'b1;

    // Verdict in precedence order, then start a fresh image
    if (fin) begin
      cut_short = (walk_phase == P_LENGTH) ||
                  (walk_phase == P_NAME && walk_name_start != nx) ||
                  ((walk_phase == P_PAD_HEAD || walk_phase == P_DATA) &&
                   walk_data_left != 0);
      rec[n]             = '0;
      rec[n].kind        = bsv_pkg::KIND_VERDICT;
      if (typed) rec[n].status = typed_status;
      else if (!was_wrapped && p < bsv_pkg::MIN_LEN - 1) rec[n].status = bsv_pkg::STATUS_SHORT;
      else if (!walk_magic_good) rec[n].status = bsv_pkg::STATUS_BAD_MAGIC;
      else if (walk_hash != walk_stored_sum) rec[n].status = bsv_pkg::STATUS_CHECKSUM;
      else if (cut_short) rec[n].status = bsv_pkg::STATUS_TRUNC;
      else rec[n].status = bsv_pkg::STATUS_OK;
      n++;
      clear_walk();
    end
    if (n > 0) rec[n - 1].last_in_run = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(rec[i]);
  endtask

  // Offer one request, idling at random first, and predict it once accepted
  task automatic send_request(input logic [7:0] b, input logic fin, input logic typed,
                              input logic [2:0] typed_status);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte  <= b;
    last       <= fin;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    walk_byte(b, fin, typed, typed_status);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [31:0] image_fnv();
    logic [31:0] h;
    h = bsv_pkg::FNV_BASIS;
    for (int i = 16; i < image_bytes.size(); i++) begin
      h = (h ^ {24'd0, image_bytes[i]}) * bsv_pkg::FNV_PRIME;
    end
    return h;
  endfunction

  function automatic void pad_to_block();
    while (image_bytes.size() % 16 != 0) begin
      image_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
    end
  endfunction

  // Append one entry; an open entry carries a random length and stops in its data
  function automatic void add_entry(input logic open);
    int          name_chars;
    int          body;
    logic [31:0] dlen;
    name_chars = ($urandom_range(5) == 0) ? $urandom_range(40, 0) : $urandom_range(10, 0);
    for (int i = 0; i < name_chars; i++) image_bytes.push_back(8'($urandom_range(255, 1)));
    image_bytes.push_back(8'h00);
    if (open) dlen = $urandom;
    else if ($urandom_range(5) == 0) dlen = 32'd0;
    else dlen = $urandom_range(48, 1);
    for (int i = 3; i >= 0; i--) image_bytes.push_back(dlen[8 * i +: 8]);
    pad_to_block();
    body = open ? $urandom_range(20, 0) : int'(dlen);
    for (int i = 0; i < body; i++) image_bytes.push_back(8'($urandom));
    if (!open) pad_to_block();
  endfunction

  // Build one container image of the given flavour
  function automatic void build_image(input image_flavour_t flavour);
    int          entries;
    int          cut;
    int          k;
    logic [31:0] sum;
    image_bytes.delete();
    if (flavour == IMG_STUB) begin
      k = $urandom_range(31, 1);
      for (int i = 0; i < k; i++) image_bytes.push_back(8'($urandom));
      return;
    end
    for (int i = 0; i < 8; i++) image_bytes.push_back(HDR_MAGIC[63 - 8 * i -: 8]);
    for (int i = 0; i < 4; i++) image_bytes.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) image_bytes.push_back(8'h00);
    entries = $urandom_range(4, 0);
    for (int i = 0; i < entries; i++) add_entry(1'b0);
    while (image_bytes.size() < bsv_pkg::MIN_LEN) add_entry(1'b0);
    if (flavour == IMG_CUT) begin
      if ($urandom_range(3) == 0) begin
        add_entry(1'b1);
      end else begin
        cut = $urandom_range(image_bytes.size() - 1, 20);
        while (image_bytes.size() > cut) void'(image_bytes.pop_back());
      end
    end
    sum = image_fnv();
    for (int i = 0; i < 4; i++) image_bytes[12 + i] = sum[31 - 8 * i -: 8];
    k = $urandom_range(7);
    if (flavour == IMG_BAD_SUM) image_bytes[12 + k[1:0]] ^= 8'(1 << $urandom_range(7));
    if (flavour == IMG_BAD_MAGIC) image_bytes[k] ^= 8'(1 << $urandom_range(7));
  endfunction

  // Compare a taken result with the oldest expectation
  task automatic check_result();
    bsv_pkg::result_t got;
    bsv_pkg::result_t want;
    got.kind        = kind;
    got.name_offset = name_offset;
    got.name_length = name_length;
    got.data_offset = data_offset;
    got.data_length = data_length;
    got.status      = status;
    got.last_in_run = last_in_run;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: unexpected result kind=%0d status=%0d", $realtime, got.kind,
                 got.status);
      end
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.name_offset !== want.name_offset ||
          got.name_length !== want.name_length || got.data_offset !== want.data_offset ||
          got.data_length !== want.data_length || got.status !== want.status ||
          got.last_in_run !== want.last_in_run) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch kind %0d/%0d noff %0h/%0h nlen %0h/%0h", $realtime,
                   want.kind, got.kind, want.name_offset, got.name_offset,
                   want.name_length, got.name_length);
          $display("    doff %0h/%0h dlen %0h/%0h status %0d/%0d lir %0d/%0d",
                   want.data_offset, got.data_offset, want.data_length, got.data_length,
                   want.status, got.status, want.last_in_run, got.last_in_run);
        end
      end
    end
  endtask

  // Take results and stall the result channel at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) check_result();
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Reset, directed rows, random images, then wind down
  initial begin
    logic [12:0]    row;
    int             sent;
    int             waited;
    int             pick;
    image_flavour_t flavour;
    clear_walk();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 24; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row[7:0], row[8], row[12], row[11:9]);
    end
    drain_results();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= 2 * RANDOM_BYTES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent >= RANDOM_BYTES / 3) begin
        send_idle = 70;
        recv_idle = 15;
      end
      pick = $urandom_range(99);
      if (pick < 40) flavour = IMG_CLEAN;
      else if (pick < 55) flavour = IMG_CUT;
      else if (pick < 70) flavour = IMG_BAD_SUM;
      else if (pick < 80) flavour = IMG_BAD_MAGIC;
      else flavour = IMG_STUB;
      build_image(flavour);
      for (int i = 0; i < image_bytes.size(); i++) begin
        send_request(image_bytes[i], i == image_bytes.size() - 1, 1'b0, bsv_pkg::STATUS_OK);
      end
      sent += image_bytes.size();
      if ($urandom_range(9) == 0) drain_results();
    end

    // Wait out the tail, then count anything still owed
    item_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** bundle_stream_validator_unit: PASSED **");
    end else begin
      $display("** bundle_stream_validator_unit: FAILED **");
    end
    $finish;
  end

endmodule
